### sv/roet_pkg.sv
// Package for the repeat-offender escalation table.
// Shared constants and controller/datapath command and status types; no dependencies.
`default_nettype none
package roet_pkg;
    localparam int TableDepth = 64;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = 7;
    localparam int FactW      = 21;
    localparam int StartW     = 41;
    localparam int TimeW      = 40;
    localparam int DurW       = 24;
    localparam int ForceW     = 20;

    localparam logic [FactW-1:0]  FactorMax    = 21'd1048575;
    localparam logic [FactW-1:0]  FactorCapped = 21'h1FFFFF;
    localparam logic [StartW-1:0] StartMax     = {StartW{1'b1}};

    localparam logic [1:0] RegExpiry = 2'd0;
    localparam logic [1:0] RegGrowth = 2'd1;
    localparam logic [1:0] RegMaxDur = 2'd2;
    localparam logic [1:0] RegBlack  = 2'd3;

    typedef struct packed {
        logic          load;      // capture the event
        logic          scan;      // examine entry scan_idx
        logic [IdxW-1:0] scan_idx;
        logic          rd;        // read entry at hit index
        logic          mul1;      // first multiply
        logic          mul2;      // second multiply and update
        logic          finish;    // present the result
    } t_cmd;

    typedef struct packed {
        logic hit;
    } t_sts;
endpackage
`default_nettype wire

### sv/repeat_offender_escalation_table.sv
// Repeat-offender escalation table, top level: config registers, controller, datapath.
// Sequence: from the accepting edge, a scan over every entry of the single-port entry store,
// a drain state to retire the last scanned entry, a read, two multiply steps and a result
// state that raises o_valid; the word is taken at the edge after.
// A new event is taken only while busy is low; results cannot be stalled.
// Reset (synchronous, active low) clears every entry valid bit and loads register defaults.
`default_nettype none
module repeat_offender_escalation_table (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [23:0]  i_cfg_data,
    input  wire logic [63:0]  i_address_high,
    input  wire logic [63:0]  i_address_low,
    input  wire logic [39:0]  i_now_time,
    input  wire logic [23:0]  i_base_duration,
    input  wire logic         i_was_blacklisted,
    input  wire logic [19:0]  i_forced_factor,
    output logic              o_valid,
    output logic signed [20:0] o_factor,
    output logic [6:0]        o_entry_count,
    output logic              o_table_full
);
    logic [23:0] r_expiry, r_max_dur, r_black_dur;
    logic [7:0]  r_growth;
    roet_pkg::t_cmd cmd;
    roet_pkg::t_sts sts;

    // hold configuration; write only while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= 24'd3600; r_growth <= 8'd2;
            r_max_dur <= 24'd604800; r_black_dur <= 24'd86400;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                roet_pkg::RegExpiry: r_expiry    <= i_cfg_data;
                roet_pkg::RegGrowth: r_growth    <= i_cfg_data[7:0];
                roet_pkg::RegMaxDur: r_max_dur   <= i_cfg_data;
                roet_pkg::RegBlack:  r_black_dur <= i_cfg_data;
                default: ;
            endcase
        end
    end

    roet_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    roet_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_address_high, .i_address_low, .i_now_time, .i_base_duration,
        .i_was_blacklisted, .i_forced_factor,
        .i_expiry(r_expiry), .i_growth(r_growth), .i_max_dur(r_max_dur),
        .i_black_dur(r_black_dur),
        .o_valid, .o_factor, .o_entry_count, .o_table_full
    );
endmodule
`default_nettype wire

### sv/roet_ctrl.sv
// Controller for the escalation table: sequences the scan and update.
// Depends on roet_pkg.
`default_nettype none
module roet_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire roet_pkg::t_sts i_sts,
    output roet_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_READ, S_MUL1, S_MUL2, S_DONE
    } t_state;
    t_state r_state, n_state;
    logic [roet_pkg::IdxW-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.scan_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_idx = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == roet_pkg::IdxW'(roet_pkg::TableDepth - 1)) n_state = S_DRAIN;
            end
            // let the last scanned entry retire so the hit index is final
            S_DRAIN: begin
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd = i_sts.hit;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_idx == roet_pkg::IdxW'(roet_pkg::TableDepth - 1))
        |=> r_state == S_DRAIN) else $error("scan did not end");
    a_fin_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_cmd.finish) else $error("finish repeated");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> $past(1'b1) && !o_busy) else $error("load while busy");
endmodule
`default_nettype wire

### sv/roet_dp.sv
// Datapath for the escalation table: entry store, scan, escalation arithmetic.
// Depends on roet_pkg.
`default_nettype none
module roet_dp (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire roet_pkg::t_cmd i_cmd,
    output roet_pkg::t_sts    o_sts,
    input  wire logic [63:0]  i_address_high,
    input  wire logic [63:0]  i_address_low,
    input  wire logic [39:0]  i_now_time,
    input  wire logic [23:0]  i_base_duration,
    input  wire logic         i_was_blacklisted,
    input  wire logic [19:0]  i_forced_factor,
    input  wire logic [23:0]  i_expiry,
    input  wire logic [7:0]   i_growth,
    input  wire logic [23:0]  i_max_dur,
    input  wire logic [23:0]  i_black_dur,
    output logic              o_valid,
    output logic signed [20:0] o_factor,
    output logic [6:0]        o_entry_count,
    output logic              o_table_full
);
    localparam int D = roet_pkg::TableDepth;
    localparam int IW = roet_pkg::IdxW;

    logic [D-1:0] r_vld;
    logic [63:0]  m_ah [D];
    logic [63:0]  m_al [D];
    logic [20:0]  m_f  [D];
    logic [40:0]  m_s  [D];

    logic [63:0] r_ah, r_al;
    logic [39:0] r_now;
    logic [23:0] r_dur;
    logic        r_blk;
    logic [19:0] r_frc;
    logic        r_hit, r_slot_ok;
    logic [IW-1:0] r_hit_i, r_slot_i;
    logic [20:0] r_cur;
    logic [40:0] r_cst;
    logic [28:0] r_nf;      // escalated factor before saturation
    logic [20:0] r_nfs;
    logic [23:0] r_d;
    logic [IW:0] r_cnt;

    // registered read of the scanned entry, or of the hit entry on rd
    logic [63:0] s_ah, s_al;
    logic [40:0] s_s;

    logic [IW-1:0] ridx;
    assign ridx = i_cmd.rd ? r_hit_i : i_cmd.scan_idx;
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan || i_cmd.rd) begin
            s_ah <= m_ah[ridx];
            s_al <= m_al[ridx];
            s_s  <= m_s[ridx];
            r_cur <= m_f[ridx];
        end
    end

    // scan is pipelined over the registered read; r_sv and r_si are registered to line up with it
    logic          r_sv;
    logic [IW-1:0] r_si;
    logic [41:0]   exp_t;
    logic          live;
    assign exp_t = {1'b0, s_s} + 42'(i_expiry);
    assign live  = r_vld[r_si] && ({2'b0, r_now} < exp_t);

    function automatic logic [40:0] sat_add(input logic [39:0] a, input logic [44:0] b);
        logic [45:0] s;
        s = 46'(a) + 46'(b);
        return (s > 46'(roet_pkg::StartMax)) ? roet_pkg::StartMax : s[40:0];
    endfunction

    logic [43:0] r_p2;
    logic [20:0] nf_sat;
    assign nf_sat = (r_nf > 29'(roet_pkg::FactorMax)) ? roet_pkg::FactorMax : r_nf[20:0];
    logic [20:0] new_f;
    assign new_f = (r_frc != '0) ? 21'(r_frc) : 21'd1;
    logic [43:0] r_pn;

    logic pass, cap_keep;
    assign pass = {1'b0, r_now} > r_cst;
    assign cap_keep = (r_cur == roet_pkg::FactorCapped) && (r_frc == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0; r_sv <= 1'b0; o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_sv <= i_cmd.scan;
            r_si <= i_cmd.scan_idx;
            if (i_cmd.load) begin
                r_ah <= i_address_high; r_al <= i_address_low; r_now <= i_now_time;
                r_dur <= i_base_duration; r_blk <= i_was_blacklisted;
                r_frc <= i_forced_factor;
                r_hit <= 1'b0; r_slot_ok <= 1'b0; r_cnt <= '0;
                r_hit_i <= '0; r_slot_i <= '0;
            end
            // expire, match and find free slot, one entry a cycle
            if (r_sv) begin
                if (!live) begin
                    r_vld[r_si] <= 1'b0;
                    if (!r_slot_ok) begin r_slot_ok <= 1'b1; r_slot_i <= r_si; end
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    if (!r_hit && s_ah == r_ah && s_al == r_al) begin
                        r_hit <= 1'b1; r_hit_i <= r_si;
                    end
                end
            end
            if (i_cmd.mul1) begin
                r_cst <= s_s;
                r_nf  <= (r_frc != '0) ? 29'(r_frc) : 29'(r_cur) * 29'(i_growth);
                r_d   <= r_blk ? i_black_dur : r_dur;
            end
            if (i_cmd.mul2) begin
                r_nfs <= nf_sat;
                r_p2  <= 44'(r_d) * 44'(nf_sat);
                r_pn  <= 44'(new_f) * 44'(r_dur);
            end
            if (i_cmd.finish) begin
                o_valid <= 1'b1;
                o_table_full <= 1'b0;
                o_entry_count <= 7'(r_cnt);
                if (!r_hit) begin
                    o_factor <= new_f;
                    if (!r_slot_ok) o_table_full <= 1'b1;
                    else begin
                        r_vld[r_slot_i] <= 1'b1;
                        m_ah[r_slot_i] <= r_ah; m_al[r_slot_i] <= r_al;
                        m_f[r_slot_i] <= new_f;
                        m_s[r_slot_i] <= sat_add(r_now, 45'(r_pn));
                        o_entry_count <= 7'(r_cnt + 1'b1);
                    end
                end else if (!pass) begin
                    o_factor <= r_cur;
                end else if (cap_keep) begin
                    o_factor <= r_cur;
                    m_s[r_hit_i] <= sat_add(r_now, 45'(i_max_dur));
                end else if (r_p2 < 44'(i_max_dur)) begin
                    o_factor <= r_nfs;
                    m_f[r_hit_i] <= r_nfs;
                    m_s[r_hit_i] <= sat_add(r_now, 45'(r_p2));
                end else begin
                    o_factor <= roet_pkg::FactorCapped;
                    m_f[r_hit_i] <= roet_pkg::FactorCapped;
                    m_s[r_hit_i] <= sat_add(r_now, 45'(i_max_dur));
                end
            end
        end
    end

    assign o_sts.hit = r_hit;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= 7'(D)) else $error("count too big");
    a_full_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> !r_hit) else $error("full with hit");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result repeated");
endmodule
`default_nettype wire
